>>> rtl/gapf_pkg.sv
// Shared types, codes and constants of the grid A* path finder.
package gapf_pkg;

   localparam int DEF_MAX_WIDTH  = 64;
   localparam int DEF_MAX_HEIGHT = 64;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_X      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_Y      = 2'd3;

   localparam logic [6:0] GRID_DIM_RESET = 7'd64;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_SEARCH = 2'd1;
   localparam logic [1:0] OP_STEP   = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [2:0] ST_LOADED    = 3'd0;
   localparam logic [2:0] ST_FOUND     = 3'd1;
   localparam logic [2:0] ST_AT_DEST   = 3'd2;
   localparam logic [2:0] ST_NO_PATH   = 3'd3;
   localparam logic [2:0] ST_EXHAUSTED = 3'd4;

   localparam logic [2:0] DIR_NONE  = 3'd0;
   localparam logic [2:0] DIR_NORTH = 3'd1;
   localparam logic [2:0] DIR_SOUTH = 3'd2;
   localparam logic [2:0] DIR_EAST  = 3'd3;
   localparam logic [2:0] DIR_WEST  = 3'd4;

   localparam logic [1:0] NB_NORTH = 2'd0;
   localparam logic [1:0] NB_SOUTH = 2'd1;
   localparam logic [1:0] NB_WEST  = 2'd2;
   localparam logic [1:0] NB_EAST  = 2'd3;

   localparam int G_WEIGHT = 1000;
   localparam int H_WEIGHT = 1001;

   typedef struct packed {
      logic [1:0] opcode;
      logic [5:0] cell_x;
      logic [5:0] cell_y;
      logic       blocked;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  step_x;
      logic [5:0]  step_y;
      logic [2:0]  direction;
      logic [12:0] path_length;
   } rsp_type;

   typedef struct packed {
      logic       latch_req;
      logic       load_blk;
      logic       count_clear;
      logic       clr_start;
      logic       clr_write;
      logic       start_write;
      logic       scan_start;
      logic       scan_issue;
      logic       close_best;
      logic       nb_set;
      logic       nb_next;
      logic       nb_issue;
      logic       nb_write;
      logic       path_first;
      logic       path_push;
      logic       path_follow;
      logic       pop_issue;
      logic       rsp_load;
      logic       rsp_from_pop;
      logic [2:0] rsp_status;
   } cmd_type;

   typedef struct packed {
      logic [1:0] req_op;
      logic       req_same;
      logic       req_out;
      logic       count_zero;
      logic       count_full;
      logic       clr_last;
      logic       scan_last;
      logic       scan_busy;
      logic       best_any;
      logic       best_is_dest;
      logic       nb_ok;
      logic       nb_last;
      logic       cur_is_start;
   } sts_type;

endpackage

>>> rtl/gapf_ctrl.sv
// Sequencer of the grid A* path finder: decodes words and steps the search.
module gapf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  gapf_pkg::sts_type sts,
   output gapf_pkg::cmd_type cmd
);
   import gapf_pkg::*;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_CLEAR     = 4'd1;
   localparam logic [3:0] S_INIT      = 4'd2;
   localparam logic [3:0] S_SCAN      = 4'd3;
   localparam logic [3:0] S_DRAIN     = 4'd4;
   localparam logic [3:0] S_NB_RD     = 4'd5;
   localparam logic [3:0] S_NB_WR     = 4'd6;
   localparam logic [3:0] S_PATH_CHK  = 4'd7;
   localparam logic [3:0] S_PATH_WAIT = 4'd8;
   localparam logic [3:0] S_STEP      = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_ok;

   assign slot_ok   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_IDLE) && slot_ok);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && slot_ok) begin
               cmd.latch_req = 1'b1;
               case (sts.req_op)
                  OP_LOAD: begin
                     cmd.load_blk   = 1'b1;
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = ST_LOADED;
                  end
                  OP_SEARCH: begin
                     cmd.count_clear = 1'b1;
                     if (sts.req_same) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = ST_AT_DEST;
                     end else if (sts.req_out) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = ST_NO_PATH;
                     end else begin
                        cmd.clr_start = 1'b1;
                        state_in      = S_CLEAR;
                     end
                  end
                  OP_STEP: begin
                     if (sts.count_zero) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = ST_EXHAUSTED;
                     end else begin
                        cmd.pop_issue = 1'b1;
                        state_in      = S_STEP;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (sts.clr_last) state_in = S_INIT;
         end
         S_INIT: begin
            cmd.start_write = 1'b1;
            cmd.scan_start  = 1'b1;
            state_in        = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (sts.scan_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (!sts.scan_busy) begin
               if (!sts.best_any) begin
                  cmd.rsp_load   = 1'b1;
                  cmd.rsp_status = ST_NO_PATH;
                  state_in       = S_IDLE;
               end else if (sts.best_is_dest) begin
                  cmd.path_first = 1'b1;
                  state_in       = S_PATH_CHK;
               end else begin
                  cmd.close_best = 1'b1;
                  cmd.nb_set     = 1'b1;
                  state_in       = S_NB_RD;
               end
            end
         end
         S_NB_RD: begin
            if (sts.nb_ok) begin
               cmd.nb_issue = 1'b1;
               state_in     = S_NB_WR;
            end else if (sts.nb_last) begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end else begin
               cmd.nb_next = 1'b1;
            end
         end
         S_NB_WR: begin
            cmd.nb_write = 1'b1;
            if (sts.nb_last) begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end else begin
               cmd.nb_next = 1'b1;
               state_in    = S_NB_RD;
            end
         end
         S_PATH_CHK: begin
            if (sts.cur_is_start || sts.count_full) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = ST_FOUND;
               state_in       = S_IDLE;
            end else begin
               cmd.path_push = 1'b1;
               state_in      = S_PATH_WAIT;
            end
         end
         S_PATH_WAIT: begin
            cmd.path_follow = 1'b1;
            state_in        = S_PATH_CHK;
         end
         S_STEP: begin
            cmd.rsp_load     = 1'b1;
            cmd.rsp_from_pop = 1'b1;
            cmd.rsp_status   = ST_FOUND;
            state_in         = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/gapf_dp.sv
// Datapath of the grid A* path finder: cell memories, open-set scan, relax, path stack.
module gapf_dp #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  gapf_pkg::cmd_type cmd,
   output gapf_pkg::sts_type sts,
   input  gapf_pkg::req_type req_data,
   input  logic [6:0]        grid_width,
   input  logic [6:0]        grid_height,
   input  logic [5:0]        dest_x,
   input  logic [5:0]        dest_y,
   output gapf_pkg::rsp_type rsp_data
);
   import gapf_pkg::*;

   localparam int NCELLS = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW     = $clog2(NCELLS);
   localparam int XW     = $clog2(MAX_WIDTH);
   localparam int YW     = $clog2(MAX_HEIGHT);
   localparam int CNTW   = $clog2(NCELLS + 1);
   localparam int GW     = CNTW;
   localparam int HW     = ((XW > YW) ? XW : YW) + 1;
   localparam int FW     = GW + HW + 11;
   localparam int CW     = 10;

   typedef struct packed {
      logic          open;
      logic          closed;
      logic [GW-1:0] cost;
      logic [YW-1:0] py;
      logic [XW-1:0] px;
   } node_type;

   function automatic logic [AW-1:0] cell_addr(input logic [YW-1:0] y,
                                               input logic [XW-1:0] x);
      logic [AW-1:0] row;
      row       = AW'(y) * AW'(MAX_WIDTH);
      cell_addr = row + AW'(x);
   endfunction

   // storage
   node_type            node_mem  [NCELLS];
   logic                blk_mem   [NCELLS];
   logic [YW+XW-1:0]    stack_mem [NCELLS];

   node_type            node_rd_ff;
   logic                blk_rd_ff;
   logic [YW+XW-1:0]    stack_rd_ff;

   // effective grid size and destination
   logic [CW-1:0] w_eff, h_eff, gw_ext, gh_ext;
   logic [XW-1:0] dxt;
   logic [YW-1:0] dyt;

   assign gw_ext = CW'(grid_width);
   assign gh_ext = CW'(grid_height);
   assign w_eff  = (gw_ext == '0) ? CW'(1) :
                   ((gw_ext > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : gw_ext);
   assign h_eff  = (gh_ext == '0) ? CW'(1) :
                   ((gh_ext > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : gh_ext);
   assign dxt    = XW'(dest_x);
   assign dyt    = YW'(dest_y);

   // latched request coordinates
   logic [5:0]    req_x_ff, req_y_ff;
   logic [XW-1:0] st_x;
   logic [YW-1:0] st_y;
   assign st_x = XW'(req_x_ff);
   assign st_y = YW'(req_y_ff);

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         req_x_ff <= req_data.cell_x;
         req_y_ff <= req_data.cell_y;
      end
   end

   // load path
   logic          blk_we;
   logic [AW-1:0] blk_wa;
   assign blk_we = cmd.load_blk && (CW'(req_data.cell_x) < CW'(MAX_WIDTH))
                   && (CW'(req_data.cell_y) < CW'(MAX_HEIGHT));
   assign blk_wa = cell_addr(YW'(req_data.cell_y), XW'(req_data.cell_x));

   // clearing pass
   logic [AW-1:0] clr_addr_ff;
   always_ff @(posedge clock) begin
      if (cmd.clr_start) clr_addr_ff <= '0;
      else if (cmd.clr_write) clr_addr_ff <= clr_addr_ff + AW'(1);
   end

   // scan counters
   logic [XW-1:0] sc_x_ff;
   logic [YW-1:0] sc_y_ff;
   logic          sc_row_end;
   assign sc_row_end = (CW'(sc_x_ff) == w_eff - CW'(1));

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         sc_x_ff <= '0;
         sc_y_ff <= '0;
      end else if (cmd.scan_issue) begin
         if (sc_row_end) begin
            sc_x_ff <= '0;
            sc_y_ff <= sc_y_ff + YW'(1);
         end else begin
            sc_x_ff <= sc_x_ff + XW'(1);
         end
      end
   end

   // scan pipeline: read, weight, compare
   logic          a_v_ff, m_v_ff;
   logic [XW-1:0] a_x_ff, m_x_ff;
   logic [YW-1:0] a_y_ff, m_y_ff;
   logic [GW-1:0] m_cost_ff;
   logic [YW-1:0] m_py_ff;
   logic [XW-1:0] m_px_ff;
   logic [FW-1:0] m_g_ff, m_h_ff, f_val;
   logic [XW-1:0] hx;
   logic [YW-1:0] hy;
   logic [HW-1:0] hsum;

   assign hx   = (a_x_ff > dxt) ? (a_x_ff - dxt) : (dxt - a_x_ff);
   assign hy   = (a_y_ff > dyt) ? (a_y_ff - dyt) : (dyt - a_y_ff);
   assign hsum = HW'(hx) + HW'(hy);
   assign f_val = m_g_ff + m_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         m_v_ff <= 1'b0;
      end else begin
         a_v_ff <= cmd.scan_issue;
         m_v_ff <= a_v_ff && node_rd_ff.open;
      end
      a_x_ff    <= sc_x_ff;
      a_y_ff    <= sc_y_ff;
      m_x_ff    <= a_x_ff;
      m_y_ff    <= a_y_ff;
      m_cost_ff <= node_rd_ff.cost;
      m_py_ff   <= node_rd_ff.py;
      m_px_ff   <= node_rd_ff.px;
      m_g_ff    <= FW'(node_rd_ff.cost) * FW'(G_WEIGHT);
      m_h_ff    <= FW'(hsum) * FW'(H_WEIGHT);
   end

   logic          best_any_ff;
   logic [FW-1:0] best_f_ff;
   logic [XW-1:0] best_x_ff, best_px_ff;
   logic [YW-1:0] best_y_ff, best_py_ff;
   logic [GW-1:0] best_cost_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         best_any_ff <= 1'b0;
      end else if (cmd.scan_start) begin
         best_any_ff <= 1'b0;
      end else if (m_v_ff && (!best_any_ff || (f_val < best_f_ff))) begin
         best_any_ff <= 1'b1;
      end
      if (m_v_ff && (!best_any_ff || (f_val < best_f_ff))) begin
         best_f_ff    <= f_val;
         best_x_ff    <= m_x_ff;
         best_y_ff    <= m_y_ff;
         best_cost_ff <= m_cost_ff;
         best_px_ff   <= m_px_ff;
         best_py_ff   <= m_py_ff;
      end
   end

   // neighbour relaxation
   logic [1:0]    nb_k_ff;
   logic [XW-1:0] nb_x;
   logic [YW-1:0] nb_y;
   logic          nb_ok;
   logic [AW-1:0] nb_addr_ff;
   logic [GW-1:0] tg;
   logic          tg_lt, open_keep, closed_keep, nb_take;

   always_comb begin
      nb_x  = best_x_ff;
      nb_y  = best_y_ff;
      nb_ok = 1'b0;
      case (nb_k_ff)
         NB_NORTH: begin
            nb_y  = best_y_ff - YW'(1);
            nb_ok = (best_y_ff != '0);
         end
         NB_SOUTH: begin
            nb_y  = best_y_ff + YW'(1);
            nb_ok = (CW'(best_y_ff) + CW'(1) < h_eff);
         end
         NB_WEST: begin
            nb_x  = best_x_ff - XW'(1);
            nb_ok = (best_x_ff != '0);
         end
         NB_EAST: begin
            nb_x  = best_x_ff + XW'(1);
            nb_ok = (CW'(best_x_ff) + CW'(1) < w_eff);
         end
         default: ;
      endcase
   end

   assign tg          = best_cost_ff + GW'(1);
   assign tg_lt       = tg < node_rd_ff.cost;
   assign open_keep   = node_rd_ff.open && !tg_lt;
   assign closed_keep = node_rd_ff.closed && !tg_lt;
   assign nb_take     = !blk_rd_ff && !open_keep && !closed_keep;

   always_ff @(posedge clock) begin
      if (cmd.nb_set) nb_k_ff <= NB_NORTH;
      else if (cmd.nb_next) nb_k_ff <= nb_k_ff + 2'd1;
      if (cmd.nb_issue) nb_addr_ff <= cell_addr(nb_y, nb_x);
   end

   // path walk and stack
   logic [XW-1:0]   cur_x_ff;
   logic [YW-1:0]   cur_y_ff;
   logic [CNTW-1:0] count_ff, count_in;

   always_ff @(posedge clock) begin
      if (cmd.path_first) begin
         cur_x_ff <= best_px_ff;
         cur_y_ff <= best_py_ff;
      end else if (cmd.path_follow) begin
         cur_x_ff <= node_rd_ff.px;
         cur_y_ff <= node_rd_ff.py;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.count_clear) count_in = '0;
      else if (cmd.path_first || cmd.path_push) count_in = count_ff + CNTW'(1);
      else if (cmd.pop_issue) count_in = count_ff - CNTW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else count_ff <= count_in;
   end

   // memory ports
   logic          node_we;
   logic [AW-1:0] node_wa, node_ra, pop_ra;
   node_type      node_wd;
   logic          stk_we;
   logic [YW+XW-1:0] stk_wd;

   always_comb begin
      node_we = 1'b0;
      node_wa = clr_addr_ff;
      node_wd = '0;
      if (cmd.clr_write) begin
         node_we = 1'b1;
      end else if (cmd.start_write) begin
         node_we      = 1'b1;
         node_wa      = cell_addr(st_y, st_x);
         node_wd.open = 1'b1;
      end else if (cmd.close_best) begin
         node_we        = 1'b1;
         node_wa        = cell_addr(best_y_ff, best_x_ff);
         node_wd.closed = 1'b1;
         node_wd.cost   = best_cost_ff;
         node_wd.py     = best_py_ff;
         node_wd.px     = best_px_ff;
      end else if (cmd.nb_write && nb_take) begin
         node_we      = 1'b1;
         node_wa      = nb_addr_ff;
         node_wd.open = 1'b1;
         node_wd.cost = tg;
         node_wd.py   = best_y_ff;
         node_wd.px   = best_x_ff;
      end
   end

   always_comb begin
      if (cmd.nb_issue) node_ra = cell_addr(nb_y, nb_x);
      else if (cmd.path_push) node_ra = cell_addr(cur_y_ff, cur_x_ff);
      else node_ra = cell_addr(sc_y_ff, sc_x_ff);
   end

   assign stk_we = cmd.path_first || cmd.path_push;
   assign stk_wd = cmd.path_first ? {best_y_ff, best_x_ff} : {cur_y_ff, cur_x_ff};
   assign pop_ra = AW'(count_ff - CNTW'(1));

   always_ff @(posedge clock) begin
      if (node_we) node_mem[node_wa] <= node_wd;
      node_rd_ff <= node_mem[node_ra];
      blk_rd_ff  <= blk_mem[node_ra];
      if (blk_we) blk_mem[blk_wa] <= req_data.blocked;
      if (stk_we) stack_mem[count_ff[AW-1:0]] <= stk_wd;
      stack_rd_ff <= stack_mem[pop_ra];
   end

   // result word
   logic [XW-1:0] pop_x;
   logic [YW-1:0] pop_y;
   logic [2:0]    pop_dir;
   rsp_type       rsp_ff;

   assign pop_x = stack_rd_ff[XW-1:0];
   assign pop_y = stack_rd_ff[YW+XW-1:XW];

   always_comb begin
      if (CW'(pop_y) > CW'(req_y_ff)) pop_dir = DIR_SOUTH;
      else if (CW'(pop_y) < CW'(req_y_ff)) pop_dir = DIR_NORTH;
      else if (CW'(pop_x) > CW'(req_x_ff)) pop_dir = DIR_EAST;
      else if (CW'(pop_x) < CW'(req_x_ff)) pop_dir = DIR_WEST;
      else pop_dir = DIR_NONE;
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.status      <= cmd.rsp_status;
         rsp_ff.step_x      <= cmd.rsp_from_pop ? 6'(pop_x) : 6'd0;
         rsp_ff.step_y      <= cmd.rsp_from_pop ? 6'(pop_y) : 6'd0;
         rsp_ff.direction   <= cmd.rsp_from_pop ? pop_dir : DIR_NONE;
         rsp_ff.path_length <= 13'(count_in);
      end
   end

   assign rsp_data = rsp_ff;

   // status to the sequencer
   always_comb begin
      sts              = '0;
      sts.req_op       = req_data.opcode;
      sts.req_same     = (req_data.cell_x == dest_x) && (req_data.cell_y == dest_y);
      sts.req_out      = (CW'(req_data.cell_x) >= w_eff) || (CW'(req_data.cell_y) >= h_eff)
                         || (CW'(dest_x) >= w_eff) || (CW'(dest_y) >= h_eff);
      sts.count_zero   = (count_ff == '0);
      sts.count_full   = (count_ff == CNTW'(NCELLS));
      sts.clr_last     = (clr_addr_ff == AW'(NCELLS - 1));
      sts.scan_last    = sc_row_end && (CW'(sc_y_ff) == h_eff - CW'(1));
      sts.scan_busy    = a_v_ff || m_v_ff;
      sts.best_any     = best_any_ff;
      sts.best_is_dest = (best_x_ff == dxt) && (best_y_ff == dyt);
      sts.nb_ok        = nb_ok;
      sts.nb_last      = (nb_k_ff == NB_EAST);
      sts.cur_is_start = (cur_x_ff == st_x) && (cur_y_ff == st_y);
   end

endmodule

>>> rtl/grid_astar_path_finder.sv
// Top level of the grid A* path finder: configuration registers, sequencer and datapath.
//
// A load word is answered straight from idle; a step word first reads the stack, then loads the result.
// A search word with start on the destination or off the grid is answered straight from idle.
// Otherwise a search first clears the open and closed marks of all
// MAX_WIDTH*MAX_HEIGHT cells, one cell per cycle, then repeats an expansion
// round until the destination is chosen or the open set is empty. Each round
// scans the width*height cells in use through the one read port of the cell
// memory, waits for the scan pipeline to drain, then relaxes up to four
// neighbors, each in-grid one with a read and a write state. Path unwinding
// takes a check and a wait state per path cell. The single-port cell memory
// scan sets the search time. No new word is taken while a search or step
// runs, or while a result word waits unclaimed.
module grid_astar_path_finder #(
   parameter int MAX_WIDTH  = gapf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = gapf_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  gapf_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output gapf_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [gapf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gapf_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import gapf_pkg::*;

   // configuration registers; the user must write them only while idle, the block does not enforce it
   logic [6:0] grid_width_ff, grid_width_in;
   logic [6:0] grid_height_ff, grid_height_in;
   logic [5:0] dest_x_ff, dest_x_in;
   logic [5:0] dest_y_ff, dest_y_in;

   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      dest_x_in      = dest_x_ff;
      dest_y_in      = dest_y_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_GRID_WIDTH:  grid_width_in  = csr_wdata[6:0];
            CSR_GRID_HEIGHT: grid_height_in = csr_wdata[6:0];
            CSR_DEST_X:      dest_x_in      = csr_wdata[5:0];
            CSR_DEST_Y:      dest_y_in      = csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_DIM_RESET;
         grid_height_ff <= GRID_DIM_RESET;
         dest_x_ff      <= '0;
         dest_y_ff      <= '0;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         dest_x_ff      <= dest_x_in;
         dest_y_ff      <= dest_y_in;
      end
   end

   // sequencer and datapath talk only through these
   cmd_type cmd;
   sts_type sts;

   gapf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   gapf_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_data    (req_data),
      .grid_width  (grid_width_ff),
      .grid_height (grid_height_ff),
      .dest_x      (dest_x_ff),
      .dest_y      (dest_y_ff),
      .rsp_data    (rsp_data)
   );

   // a word is taken only when the result slot is free or draining
   a_accept_slot_free: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (!rsp_valid || !rsp_stall))
      else $error("input word taken while result slot held");

   // a direction is only reported with a given step
   a_dir_only_on_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.direction != DIR_NONE) |-> (rsp_data.status == ST_FOUND))
      else $error("direction on a non-step result");

   // loading the result register never happens while an old word is stuck
   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid || !rsp_stall))
      else $error("result word overwritten");

   // exhausted path always reports zero remaining steps
   a_exhausted_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_EXHAUSTED) |-> (rsp_data.path_length == '0))
      else $error("exhausted result with steps left");

endmodule

>>> dv/testbench.sv
// Self-checking testbench of the grid A* path finder: scoreboard class, drivers and checks.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import gapf_pkg::*;

   localparam int NCELLS      = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
   localparam int WATCH_LIMIT = 200000;
   localparam int HOLD_CYCLES = 400;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   grid_astar_path_finder uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Mirror of the path finder: grid, search marks, path stack and registers.
   class path_scoreboard;
      bit          blk[NCELLS];
      int unsigned cost[NCELLS];
      int unsigned par[NCELLS];
      bit          opn[NCELLS];
      bit          cls[NCELLS];
      int unsigned stk[NCELLS];
      int unsigned pcnt;
      logic [6:0]  gw, gh;
      logic [5:0]  dx, dy;
      rsp_type     pending[$];
      rsp_type     last_rsp;

      function new();
         pcnt = 0; gw = GRID_DIM_RESET; gh = GRID_DIM_RESET; dx = 0; dy = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_GRID_WIDTH:  gw = val;
            CSR_GRID_HEIGHT: gh = val;
            CSR_DEST_X:      dx = val[5:0];
            CSR_DEST_Y:      dy = val[5:0];
            default: ;
         endcase
      endfunction

      function int unsigned clamp_dim(int unsigned v, int unsigned mx);
         if (v == 0) return 1;
         return (v > mx) ? mx : v;
      endfunction

      function int unsigned f_cost(int unsigned i);
         int unsigned x, y, hd;
         x = i % DEF_MAX_WIDTH;
         y = i / DEF_MAX_WIDTH;
         hd = ((x > dx) ? x - dx : dx - x) + ((y > dy) ? y - dy : dy - y);
         return G_WEIGHT * cost[i] + H_WEIGHT * hd;
      endfunction

      function void relax(int unsigned n, int unsigned from, int unsigned tg);
         if (blk[n]) return;
         if (opn[n] && tg < cost[n]) opn[n] = 0;
         if (cls[n] && tg < cost[n]) cls[n] = 0;
         if (!opn[n] && !cls[n]) begin
            cost[n] = tg; opn[n] = 1; par[n] = from;
         end
      endfunction

      function logic [2:0] find_path(int unsigned sx, int unsigned sy);
         int unsigned w, h, s, d, best, bf, f, i, bx, by, tg, c;
         bit any;
         w = clamp_dim(32'(gw), DEF_MAX_WIDTH);
         h = clamp_dim(32'(gh), DEF_MAX_HEIGHT);
         pcnt = 0;
         if (sx == dx && sy == dy) return ST_AT_DEST;
         if (sx >= w || sy >= h || dx >= w || dy >= h) return ST_NO_PATH;
         for (int k = 0; k < NCELLS; k++) begin
            opn[k] = 0; cls[k] = 0;
         end
         s = sy * DEF_MAX_WIDTH + sx;
         d = dy * DEF_MAX_WIDTH + dx;
         cost[s] = 0;
         opn[s] = 1;
         forever begin
            any = 0; best = 0; bf = 0;
            for (int unsigned y = 0; y < h; y++)
               for (int unsigned x = 0; x < w; x++) begin
                  i = y * DEF_MAX_WIDTH + x;
                  if (opn[i]) begin
                     f = f_cost(i);
                     if (!any || f < bf) begin any = 1; bf = f; best = i; end
                  end
               end
            if (!any) return ST_NO_PATH;
            if (best == d) begin
               c = par[d];
               stk[pcnt] = d; pcnt++;
               while (c != s && pcnt < NCELLS) begin
                  stk[pcnt] = c; pcnt++;
                  c = par[c % NCELLS];
               end
               return ST_FOUND;
            end
            opn[best] = 0;
            cls[best] = 1;
            bx = best % DEF_MAX_WIDTH;
            by = best / DEF_MAX_WIDTH;
            tg = cost[best] + 1;
            if (by > 0) relax(best - DEF_MAX_WIDTH, best, tg);
            if (by + 1 < h) relax(best + DEF_MAX_WIDTH, best, tg);
            if (bx > 0) relax(best - 1, best, tg);
            if (bx + 1 < w) relax(best + 1, best, tg);
         end
      endfunction

      // Predict the result of one accepted word and queue it.
      function void note_word(req_type r);
         rsp_type e;
         int unsigned c;
         e = '0;
         if (r.opcode == OP_LOAD) begin
            blk[r.cell_y * DEF_MAX_WIDTH + r.cell_x] = r.blocked;
            e.status = ST_LOADED;
         end else if (r.opcode == OP_SEARCH) begin
            e.status = find_path(32'(r.cell_x), 32'(r.cell_y));
         end else if (r.opcode == OP_STEP) begin
            if (pcnt == 0) e.status = ST_EXHAUSTED;
            else begin
               pcnt--;
               c = stk[pcnt] % NCELLS;
               e.step_x = 6'(c % DEF_MAX_WIDTH);
               e.step_y = 6'(c / DEF_MAX_WIDTH);
               if (e.step_y > r.cell_y)      e.direction = DIR_SOUTH;
               else if (e.step_y < r.cell_y) e.direction = DIR_NORTH;
               else if (e.step_x > r.cell_x) e.direction = DIR_EAST;
               else if (e.step_x < r.cell_x) e.direction = DIR_WEST;
               else                          e.direction = DIR_NONE;
               e.status = ST_FOUND;
            end
         end else return;
         e.path_length = pcnt[12:0];
         last_rsp = e;
         pending = {pending, e};
      endfunction

      // Compare one result with the oldest expectation; msg is empty on a match.
      function void check_word(rsp_type got, output string msg);
         rsp_type e;
         msg = "";
         if (pending.size() == 0) begin
            msg = $sformatf("unexpected result %p", got);
            return;
         end
         e = pending.pop_front();
         if (got.status != e.status)
            msg = {msg, $sformatf(" status %0d/%0d", got.status, e.status)};
         if (got.step_x != e.step_x)
            msg = {msg, $sformatf(" step_x %0d/%0d", got.step_x, e.step_x)};
         if (got.step_y != e.step_y)
            msg = {msg, $sformatf(" step_y %0d/%0d", got.step_y, e.step_y)};
         if (got.direction != e.direction)
            msg = {msg, $sformatf(" direction %0d/%0d", got.direction, e.direction)};
         if (got.path_length != e.path_length)
            msg = {msg, $sformatf(" path_length %0d/%0d", got.path_length, e.path_length)};
         if (msg != "") msg = {"mismatch (got/expected):", msg};
      endfunction
   endclass

   path_scoreboard sb;
   int  fail_count = 0;
   int  word_count = 0;
   int  search_count = 0;
   int  rsp_count = 0;
   bit  quiet = 0;

   initial forever #5 clock = ~clock;

   task automatic report(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      fail_count++;
   endtask

   // Mostly short gaps, now and then a long one.
   function automatic int gap_len();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic req_type make_word(logic [1:0] op, int x, int y, bit b);
      req_type r;
      r.opcode = op; r.cell_x = 6'(x); r.cell_y = 6'(y); r.blocked = b;
      return r;
   endfunction

   // Offer one word, hold it until accepted, then note it.
   task automatic send(req_type r);
      int g;
      g = (quiet || $urandom_range(0, 1)) ? 0 : gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      sb.note_word(r);
      if (r.opcode != OP_UNUSED) word_count++;
      if (r.opcode == OP_SEARCH) search_count++;
   endtask

   // Drop valid, drain all results and let any ignored word settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Drive one register write; the caller drops the enable after the last one.
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   task automatic set_grid(int w, int h, int x, int y);
      wait_idle();
      write_csr(CSR_GRID_WIDTH, CSR_DATA_W'(w));
      write_csr(CSR_GRID_HEIGHT, CSR_DATA_W'(h));
      write_csr(CSR_DEST_X, CSR_DATA_W'(x));
      write_csr(CSR_DEST_Y, CSR_DATA_W'(y));
      csr_we <= 1'b0;
   endtask

   // Walk the stored path one step at a time, one extra step to exhaust it.
   // Now and then report the next cell itself as the position (no direction).
   task automatic follow_path(int sx, int sy);
      int px, py, n, c;
      px = sx; py = sy; n = sb.pcnt;
      for (int k = 0; k <= n; k++) begin
         if (sb.pcnt > 0 && $urandom_range(0, 9) == 0) begin
            c = sb.stk[sb.pcnt - 1];
            px = c % DEF_MAX_WIDTH; py = c / DEF_MAX_WIDTH;
         end
         send(make_word(OP_STEP, px, py, 1'($urandom_range(0, 1))));
         if (sb.last_rsp.status == ST_FOUND) begin
            px = sb.last_rsp.step_x; py = sb.last_rsp.step_y;
         end
      end
   endtask

   task automatic search_and_walk(int sx, int sy);
      send(make_word(OP_SEARCH, sx, sy, 1'($urandom_range(0, 1))));
      follow_path(sx, sy);
   endtask

   // Result side: check accepted words, stall at random, and once hold off
   // long enough for the block to fill and stall its input.
   initial begin
      int run, held;
      string msg;
      run = 0; held = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            sb.check_word(rsp_data, msg);
            if (msg != "") report(msg);
            rsp_count++;
         end
         if (!held && rsp_count >= 60) begin
            held = 1; run = HOLD_CYCLES;
         end else if (run == 0 && !quiet && $urandom_range(0, 5) == 0) begin
            run = gap_len();
         end
         if (run > 0) begin
            rsp_stall <= 1'b1;
            run--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: end the run after too long without any handshake.
   initial begin
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle = 0;
         else idle++;
         if (idle >= WATCH_LIMIT) begin
            $display("watchdog expired with %0d results pending", sb.pending.size());
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      int w, h, ew, eh, sx, sy, rand_goal;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Define as free every cell a search can reach: the small grids at the
      // origin, the far corner, the first column and the first row.
      quiet = 1;
      for (int y = 0; y < DEF_MAX_HEIGHT; y++)
         for (int x = 0; x < DEF_MAX_WIDTH; x++)
            if ((x < 8 && y < 8) || (x >= DEF_MAX_WIDTH - 8 && y >= DEF_MAX_HEIGHT - 8)
                || x == 0 || y == 0)
               send(make_word(OP_LOAD, x, y, 1'b0));
      quiet = 0;

      // Reset grid, destination at the origin: start on destination, empty step.
      send(make_word(OP_SEARCH, 0, 0, 1'b1));
      send(make_word(OP_STEP, 0, 0, 1'b0));
      // Full grid, short paths at both corners.
      set_grid(64, 64, 2, 1);
      search_and_walk(0, 0);
      set_grid(64, 64, 7'h7F, 63);
      search_and_walk(63, 62);
      search_and_walk(62, 63);
      // Width zero acts as one, height above maximum acts as maximum.
      set_grid(0, 127, 0, 63);
      search_and_walk(0, 60);
      send(make_word(OP_SEARCH, 5, 60, 1'b0));
      set_grid(127, 1, 63, 0);
      search_and_walk(60, 0);
      // Start on destination outside the grid in use still wins.
      set_grid(4, 4, 5, 5);
      send(make_word(OP_SEARCH, 5, 5, 1'b0));
      send(make_word(OP_SEARCH, 0, 0, 1'b0));
      // Blocked destination, walled-off destination, blocked start.
      set_grid(4, 4, 3, 3);
      send(make_word(OP_LOAD, 3, 3, 1'b1));
      send(make_word(OP_SEARCH, 0, 0, 1'b0));
      send(make_word(OP_LOAD, 3, 3, 1'b0));
      send(make_word(OP_LOAD, 2, 3, 1'b1));
      send(make_word(OP_LOAD, 3, 2, 1'b1));
      send(make_word(OP_SEARCH, 0, 0, 1'b0));
      send(make_word(OP_LOAD, 3, 2, 1'b0));
      send(make_word(OP_LOAD, 0, 0, 1'b1));
      search_and_walk(0, 0);
      send(make_word(OP_UNUSED, 1, 1, 1'b1));

      // Random phases on small grids: reload, search, walk, with noise mixed in.
      rand_goal = word_count + 480;
      while (word_count < rand_goal) begin
         w = $urandom_range(0, 8);
         h = $urandom_range(0, 8);
         ew = (w == 0) ? 1 : w;
         eh = (h == 0) ? 1 : h;
         set_grid(w, h, $urandom_range(0, ew), $urandom_range(0, eh));
         quiet = ($urandom_range(0, 3) == 0);
         for (int y = 0; y < eh; y++)
            for (int x = 0; x < ew; x++)
               send(make_word(OP_LOAD, x, y, $urandom_range(0, 3) == 0));
         repeat (3) begin
            if ($urandom_range(0, 9) == 0) begin
               sx = $urandom_range(0, 63); sy = $urandom_range(0, 63);
            end else begin
               sx = $urandom_range(0, ew - 1); sy = $urandom_range(0, eh - 1);
            end
            search_and_walk(sx, sy);
            case ($urandom_range(0, 3))
               0: send(make_word(OP_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                                 1'b0));
               1: send(make_word(OP_LOAD, $urandom_range(0, 63), $urandom_range(0, 63),
                                 1'($urandom_range(0, 1))));
               2: send(make_word(OP_STEP, $urandom_range(0, 63), $urandom_range(0, 63), 1'b1));
               default: ;
            endcase
         end
      end
      quiet = 0;

      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.pending.size() != 0) report("expected results left over");

      $display("covered %0d words (%0d searches) and %0d results", word_count,
               search_count, rsp_count);
      $display("grids from 1x1 to 64x64, blocked and walled-off destinations, long output stall");
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
